// ----- src/morse_paddle_keyer_unit_macros.svh -----
// assertion macros for the morse paddle keyer
`ifndef MORSE_PADDLE_KEYER_UNIT_MACROS_SVH
`define MORSE_PADDLE_KEYER_UNIT_MACROS_SVH

// concurrent check on the rising clock edge, switched off while reset is high
`define MPK_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// concurrent check on the rising clock edge that also holds through reset
`define MPK_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- src/mpk_pkg.sv -----
// types and constants shared by the morse paddle keyer
package mpk_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MARK = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DIT  = 2'd1,
    KIND_DAH  = 2'd2
  } kind_t;

  localparam logic [2:0] MODE_STRAIGHT     = 3'd0;
  localparam logic [2:0] MODE_BUG          = 3'd1;
  localparam logic [2:0] MODE_EBUG         = 3'd2;
  localparam logic [2:0] MODE_SINGLE_DOT   = 3'd3;
  localparam logic [2:0] MODE_PLAIN_IAMBIC = 3'd4;
  localparam logic [2:0] MODE_IAMBIC_A     = 3'd5;

  localparam logic [1:0] REG_KEYER_MODE = 2'd0;
  localparam logic [1:0] REG_DIT_LENGTH = 2'd1;
  localparam logic [1:0] REG_DAH_LENGTH = 2'd2;
  localparam logic [1:0] REG_GAP_LENGTH = 2'd3;

  localparam logic [2:0] RESET_MODE       = MODE_STRAIGHT;
  localparam logic [7:0] RESET_DIT_LENGTH = 8'd5;
  localparam logic [7:0] RESET_DAH_LENGTH = 8'd15;
  localparam logic [7:0] RESET_GAP_LENGTH = 8'd5;

  typedef struct packed {
    logic [2:0] keyer_mode;
    logic [7:0] dit_length;
    logic [7:0] dah_length;
    logic [7:0] gap_length;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    kind_t      current_kind;
    kind_t      previous_kind;
    kind_t      latest_press;
    logic [7:0] ticks_remaining;
    logic       dit_was_down;
    logic       dah_was_down;
    logic       extra_queued;
    logic       tone_level;
  } keyer_state_t;

  localparam keyer_state_t STATE_RESET = '{
    phase:           PH_IDLE,
    current_kind:    KIND_NONE,
    previous_kind:   KIND_NONE,
    latest_press:    KIND_NONE,
    ticks_remaining: 8'd0,
    dit_was_down:    1'b0,
    dah_was_down:    1'b0,
    extra_queued:    1'b0,
    tone_level:      1'b0
  };

endpackage

// ----- src/mpk_in_if.sv -----
// paddle sample channel: valid, ready and the two paddle levels
interface mpk_in_if;
  logic valid;
  logic ready;
  logic dit_paddle;
  logic dah_paddle;

  modport source (output valid, output dit_paddle, output dah_paddle, input ready);
  modport sink (input valid, input dit_paddle, input dah_paddle, output ready);
endinterface

// ----- src/mpk_out_if.sv -----
// keyer result channel: valid, ready, tone and element being sent
interface mpk_out_if;
  logic       valid;
  logic       ready;
  logic       tone;
  logic [1:0] sending_element;

  modport source (output valid, output tone, output sending_element, input ready);
  modport sink (input valid, input tone, input sending_element, output ready);
endinterface

// ----- src/mpk_cfg.sv -----
// configuration registers of the keyer
module mpk_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          write_enable,
  input  logic [1:0]    reg_index,
  input  logic [7:0]    write_data,
  output mpk_pkg::cfg_t cfg
);
  import mpk_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keyer_mode <= RESET_MODE;
      cfg.dit_length <= RESET_DIT_LENGTH;
      cfg.dah_length <= RESET_DAH_LENGTH;
      cfg.gap_length <= RESET_GAP_LENGTH;
    end else if (write_enable) begin
      case (reg_index)
        REG_KEYER_MODE: cfg.keyer_mode <= write_data[2:0];
        REG_DIT_LENGTH: cfg.dit_length <= write_data;
        REG_DAH_LENGTH: cfg.dah_length <= write_data;
        REG_GAP_LENGTH: cfg.gap_length <= write_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/mpk_step.sv -----
// next-state logic for one timing tick of the keyer
module mpk_step (
  input  mpk_pkg::cfg_t         cfg,
  input  mpk_pkg::keyer_state_t cur,
  input  logic                  dit,
  input  logic                  dah,
  output mpk_pkg::keyer_state_t nxt
);
  import mpk_pkg::*;

  logic       dit_new;
  logic       dah_new;
  logic       timed;
  logic [7:0] tick_dec;
  logic       start;
  kind_t      start_kind;
  kind_t      press;
  kind_t      iambic_kind;

  // squeeze alternates on the last element (or latest press); a lone paddle decides
  always_comb begin
    if (dit && dah) begin
      if (cur.previous_kind == KIND_DIT) begin
        iambic_kind = KIND_DAH;
      end else if (cur.previous_kind == KIND_DAH) begin
        iambic_kind = KIND_DIT;
      end else if (press == KIND_DAH) begin
        iambic_kind = KIND_DAH;
      end else begin
        iambic_kind = KIND_DIT;
      end
    end else if (dit) begin
      iambic_kind = KIND_DIT;
    end else if (dah) begin
      iambic_kind = KIND_DAH;
    end else begin
      iambic_kind = KIND_NONE;
    end
  end

  always_comb begin
    dit_new    = dit & ~cur.dit_was_down;
    dah_new    = dah & ~cur.dah_was_down;
    press      = cur.latest_press;
    if (dit_new) press = KIND_DIT;
    if (dah_new) press = KIND_DAH;
    timed      = (cfg.keyer_mode != MODE_STRAIGHT) && (cfg.keyer_mode <= MODE_IAMBIC_A);
    tick_dec   = (cur.ticks_remaining != 8'd0) ? cur.ticks_remaining - 8'd1 : 8'd0;
    start      = 1'b0;
    start_kind = KIND_NONE;

    nxt              = cur;
    nxt.latest_press = press;

    if (timed && cur.phase == PH_MARK) begin
      if (cfg.keyer_mode == MODE_IAMBIC_A && dit && dah) nxt.extra_queued = 1'b1;
      nxt.ticks_remaining = tick_dec;
      if (tick_dec == 8'd0) begin
        nxt.phase           = PH_GAP;
        nxt.tone_level      = 1'b0;
        nxt.ticks_remaining = cfg.gap_length;
      end
    end else if (timed && cur.phase == PH_GAP) begin
      nxt.ticks_remaining = tick_dec;
      if (tick_dec == 8'd0) begin
        nxt.phase        = PH_IDLE;
        nxt.current_kind = KIND_NONE;
      end
    end else begin
      case (cfg.keyer_mode)
        MODE_BUG: begin
          if (dit) begin
            start      = 1'b1;
            start_kind = KIND_DIT;
          end else begin
            nxt.tone_level = dah;
          end
        end
        MODE_EBUG: begin
          if (dit) begin
            start      = 1'b1;
            start_kind = KIND_DIT;
          end else if (dah) begin
            start      = 1'b1;
            start_kind = KIND_DAH;
          end else begin
            nxt.tone_level = 1'b0;
          end
        end
        MODE_SINGLE_DOT: begin
          if (dit_new) begin
            start      = 1'b1;
            start_kind = KIND_DIT;
          end else begin
            nxt.tone_level = dah;
          end
        end
        MODE_IAMBIC_A: begin
          if (cur.extra_queued) begin
            nxt.extra_queued = 1'b0;
            start            = 1'b1;
            start_kind       = (cur.previous_kind == KIND_DAH) ? KIND_DIT : KIND_DAH;
          end else if (iambic_kind != KIND_NONE) begin
            start      = 1'b1;
            start_kind = iambic_kind;
          end else begin
            nxt.tone_level = 1'b0;
          end
        end
        MODE_PLAIN_IAMBIC: begin
          if (iambic_kind != KIND_NONE) begin
            start      = 1'b1;
            start_kind = iambic_kind;
          end else begin
            nxt.tone_level = 1'b0;
          end
        end
        default: begin
          // straight keying, also the unused mode codes
          nxt.phase           = PH_IDLE;
          nxt.current_kind    = KIND_NONE;
          nxt.ticks_remaining = 8'd0;
          nxt.tone_level      = dit | dah;
        end
      endcase
    end

    if (start) begin
      nxt.phase           = PH_MARK;
      nxt.current_kind    = start_kind;
      nxt.previous_kind   = start_kind;
      nxt.tone_level      = 1'b1;
      nxt.ticks_remaining = (start_kind == KIND_DAH) ? cfg.dah_length : cfg.dit_length;
    end

    nxt.dit_was_down = dit;
    nxt.dah_was_down = dah;
  end

endmodule

// ----- src/morse_paddle_keyer_unit.sv -----
// top level of the morse paddle keyer
//
// in_ch carries one paddle sample per timing tick (dit_paddle, dah_paddle);
// a transfer happens on a rising edge with valid and ready both high.
// out_ch returns exactly one result per sample: tone (key level after the
// tick) and sending_element (0 none, 1 dit, 2 dah).
// a sample lands in the input register at its transfer; once the output
// register is free or draining, its result is loaded there and offered.
// throughput: one sample per cycle while out_ch does not stall; the keyer
// state update is a single pass of logic between the input register and
// the output register.
// the configuration port (write_enable, reg_index, write_data) writes
// keyer_mode, dit_length, dah_length and gap_length; write only while idle.
// reset (rst, synchronous) empties both registers, sets the keyer state to
// idle and loads the register defaults: straight mode, lengths 5, 15, 5.
// when out_ch stalls, the output register holds its result and the input
// register can still take one more sample; in_ch.ready drops only once both
// are full.
`include "morse_paddle_keyer_unit_macros.svh"

module morse_paddle_keyer_unit (
  input  logic       clk,
  input  logic       rst,
  mpk_in_if.sink     in_ch,
  mpk_out_if.source  out_ch,
  input  logic       write_enable,
  input  logic [1:0] reg_index,
  input  logic [7:0] write_data
);
  import mpk_pkg::*;

  cfg_t         cfg;
  keyer_state_t state;
  keyer_state_t state_next;

  // input register
  logic in_valid;
  logic in_dit;
  logic in_dah;

  // output register
  logic       out_valid;
  logic       out_tone;
  logic [1:0] out_element;

  // a tick is processed when a sample waits and the result slot is free or draining
  logic fire;

  assign fire        = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || fire;

  assign out_ch.valid           = out_valid;
  assign out_ch.tone            = out_tone;
  assign out_ch.sending_element = out_element;

  mpk_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  mpk_step u_step (
    .cfg (cfg),
    .cur (state),
    .dit (in_dit),
    .dah (in_dah),
    .nxt (state_next)
  );

  // input register: refills on every transfer, empties when its tick is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_dit <= in_ch.dit_paddle;
      in_dah <= in_ch.dah_paddle;
    end
  end

  // keyer state advances once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tone    <= state_next.tone_level;
      out_element <= state_next.current_kind;
    end
  end

  // the key is on through every mark and off through every gap
  `MPK_ASSERT(a_mark_tone, clk, rst, (state.phase == PH_MARK) |-> state.tone_level, "mark without tone")
  `MPK_ASSERT(a_gap_silent, clk, rst, (state.phase == PH_GAP) |-> !state.tone_level, "tone during gap")
  // an element is named exactly while a mark or its gap runs
  `MPK_ASSERT(a_kind_phase, clk, rst, (state.phase == PH_IDLE) == (state.current_kind == KIND_NONE), "element kind and phase disagree")
  // every processed tick leaves a result in the output register
  `MPK_ASSERT(a_fire_result, clk, rst, fire |=> out_valid, "processed tick left no result")
  // a waiting sample is neither lost nor altered
  `MPK_ASSERT(a_in_hold, clk, rst, (in_valid && !fire) |=> (in_valid && $stable(in_dit) && $stable(in_dah)), "waiting sample lost")

endmodule
